[design/assert_macros.svh]
// Assertion macros used by the checker module of the design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/twre_pkg.sv]
// Types, codes and sizing constants for the threshold watch rule engine.
package twre_pkg;

   localparam int RULE_SLOTS = 16;
   localparam int SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RULE_SLOTS - 1);
   localparam int ALU_W = 35;

   localparam logic [15:0] DEFAULT_PERIOD = 16'd100;
   localparam logic [2:0] FLAG_ENTER = 3'b001;
   localparam logic [2:0] FLAG_EXIT = 3'b010;
   localparam logic [2:0] FLAG_INITIAL = 3'b100;

   typedef enum logic [1:0] {
      ACTION_SAMPLE,
      ACTION_ADD,
      ACTION_REMOVE,
      ACTION_CLEAR
   } action_type;

   typedef enum logic [2:0] {
      MODE_ABOVE,
      MODE_BELOW,
      MODE_INSIDE,
      MODE_OUTSIDE,
      MODE_CHANGED
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_BAD_ARGS,
      STATUS_FULL
   } status_type;

   typedef enum logic [1:0] {
      RUN_NONE,
      RUN_EXIT,
      RUN_ENTER
   } run_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_APPLY,
      S_TIME_SUB,
      S_TIME_CMP,
      S_EVAL_A,
      S_EVAL_B,
      S_EVAL_C,
      S_DECIDE
   } state_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [7:0]         rule_id;
      logic [2:0]         compare_mode;
      logic [2:0]         event_flags;
      logic [15:0]        eval_period;
      logic signed [31:0] level_a;
      logic signed [31:0] level_b;
      logic signed [31:0] sample_value;
      logic [31:0]        time_ms;
      logic               sample_valid;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               event_valid;
      logic [7:0]         event_rule_id;
      logic               event_state;
      logic signed [31:0] event_value;
      logic [31:0]        event_time;
      logic [1:0]         action_to_run;
   } rsp_type;

   typedef struct packed {
      logic [7:0]         key_id;
      logic [2:0]         mode;
      logic [2:0]         report_mask;
      logic [15:0]        interval;
      logic signed [31:0] engage;
      logic signed [31:0] release_level;
      logic [31:0]        last_eval;
      logic               condition;
      logic signed [31:0] reference;
      logic               primed;
   } entry_type;

endpackage

[design/twre_alu.sv]
// Shared registered subtractor whose sign gives the time and level comparisons.
module twre_alu (
   input  logic                                clock,
   input  logic signed [twre_pkg::ALU_W-1:0]   operand_x,
   input  logic signed [twre_pkg::ALU_W-1:0]   operand_y,
   output logic signed [twre_pkg::ALU_W-1:0]   result_ff,
   output logic                                negative
);

   logic signed [twre_pkg::ALU_W-1:0] result_in;

   assign result_in = operand_x - operand_y;
   assign negative = result_ff[twre_pkg::ALU_W-1];

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

endmodule

[design/threshold_watch_rule_engine_unit.sv]
// Top level of the threshold watch rule engine: sequencer, rule table and result register.
//
// One transaction is taken when start is high and busy is low. A clear-all or an add
// with an unknown mode is answered on the cycle after acceptance, and busy stays low.
// Every other transaction raises busy until the result is shown and walks the rule table
// through its single registered read port, one slot per cycle, stopping at the matching
// id or at the last slot: add and remove give their result in the apply step after the
// scan, and a sample that finds its rule then runs up to five successive subtractions on
// the one shared 35-bit subtractor (elapsed time, period check, up to three level
// comparisons) and the decision that follows them. The result strobe lasts one cycle and
// cannot be held off; a new transaction may be started in that same cycle. The table
// needs no clearing pass.
module threshold_watch_rule_engine_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  twre_pkg::req_type req_item,
   output logic              rsp_valid,
   output twre_pkg::rsp_type rsp_item
);

   function automatic logic signed [twre_pkg::ALU_W-1:0] sext32(logic signed [31:0] v);
      return {{(twre_pkg::ALU_W - 32){v[31]}}, v};
   endfunction

   function automatic logic signed [twre_pkg::ALU_W-1:0] zext32(logic [31:0] v);
      return {{(twre_pkg::ALU_W - 32){1'b0}}, v};
   endfunction

   twre_pkg::state_type state_ff, state_in;
   twre_pkg::req_type req_ff, req_in;
   logic [twre_pkg::SLOT_W-1:0] scan_ff, scan_in;
   logic [twre_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic [twre_pkg::SLOT_W-1:0] free_ff, free_in;
   logic [twre_pkg::SLOT_W-1:0] rd_idx_ff, rd_addr;
   logic found_ff, found_in;
   logic free_found_ff, free_found_in;
   logic rd_live_ff, rd_live_in;
   logic lt1_ff, lt1_in;
   logic lt2_ff, lt2_in;
   logic [twre_pkg::RULE_SLOTS-1:0] in_use_ff, in_use_in;

   twre_pkg::entry_type slot_mem [twre_pkg::RULE_SLOTS];
   twre_pkg::entry_type rd_data_ff;
   twre_pkg::entry_type wr_data;
   logic [twre_pkg::SLOT_W-1:0] wr_addr;
   logic wr_en;

   logic signed [twre_pkg::ALU_W-1:0] alu_x, alu_y, alu_ff;
   logic alu_neg;

   logic rsp_valid_ff, rsp_valid_in;
   twre_pkg::rsp_type rsp_item_ff, rsp_item_in;

   logic accept;
   logic bad_mode;
   logic scan_hit;
   logic scan_last;
   logic skip;
   logic new_state;

   assign busy = (state_ff != twre_pkg::S_IDLE);
   assign accept = start && !busy;
   assign bad_mode = (req_item.compare_mode > twre_pkg::MODE_CHANGED);
   assign scan_hit = rd_live_ff && in_use_ff[rd_idx_ff] &&
                     (rd_data_ff.key_id == req_ff.rule_id);
   assign scan_last = rd_live_ff && (rd_idx_ff == twre_pkg::LAST_SLOT);
   assign skip = rd_data_ff.primed && alu_neg;
   assign rd_addr = (state_ff == twre_pkg::S_SCAN) ? scan_ff : slot_ff;
   assign rd_live_in = (state_ff == twre_pkg::S_SCAN);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

   always_comb begin
      case (rd_data_ff.mode)
         twre_pkg::MODE_ABOVE,
         twre_pkg::MODE_BELOW:   new_state = !lt1_ff;
         twre_pkg::MODE_INSIDE:  new_state = !lt1_ff && !lt2_ff;
         twre_pkg::MODE_OUTSIDE: new_state = lt1_ff || lt2_ff;
         default:                new_state = 1'b0;
      endcase
   end

   twre_alu u_alu (
      .clock     (clock),
      .operand_x (alu_x),
      .operand_y (alu_y),
      .result_ff (alu_ff),
      .negative  (alu_neg)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         twre_pkg::S_IDLE: begin
            if (accept && req_item.action != twre_pkg::ACTION_CLEAR &&
                !(req_item.action == twre_pkg::ACTION_ADD && bad_mode)) begin
               state_in = twre_pkg::S_SCAN;
            end
         end
         twre_pkg::S_SCAN: begin
            if (scan_hit || scan_last) begin
               state_in = twre_pkg::S_APPLY;
            end
         end
         twre_pkg::S_APPLY: begin
            if (req_ff.action == twre_pkg::ACTION_SAMPLE && found_ff) begin
               state_in = twre_pkg::S_TIME_SUB;
            end else begin
               state_in = twre_pkg::S_IDLE;
            end
         end
         twre_pkg::S_TIME_SUB: state_in = twre_pkg::S_TIME_CMP;
         twre_pkg::S_TIME_CMP: state_in = twre_pkg::S_EVAL_A;
         twre_pkg::S_EVAL_A: begin
            if (skip || !req_ff.sample_valid) begin
               state_in = twre_pkg::S_IDLE;
            end else begin
               state_in = twre_pkg::S_EVAL_B;
            end
         end
         twre_pkg::S_EVAL_B: state_in = twre_pkg::S_EVAL_C;
         twre_pkg::S_EVAL_C: state_in = twre_pkg::S_DECIDE;
         twre_pkg::S_DECIDE: state_in = twre_pkg::S_IDLE;
         default:            state_in = twre_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      twre_pkg::entry_type fresh;
      twre_pkg::entry_type upd;
      twre_pkg::status_type status;
      twre_pkg::run_type run;
      logic finish;
      logic ev;
      logic ev_state;

      req_in = req_ff;
      scan_in = scan_ff;
      slot_in = slot_ff;
      free_in = free_ff;
      found_in = found_ff;
      free_found_in = free_found_ff;
      in_use_in = in_use_ff;
      lt1_in = lt1_ff;
      lt2_in = lt2_ff;
      wr_en = 1'b0;
      wr_addr = slot_ff;
      alu_x = '0;
      alu_y = '0;
      finish = 1'b0;
      status = twre_pkg::STATUS_OK;
      run = twre_pkg::RUN_NONE;
      ev = 1'b0;
      ev_state = 1'b0;

      fresh.key_id = req_ff.rule_id;
      fresh.mode = req_ff.compare_mode;
      fresh.report_mask = req_ff.event_flags;
      fresh.interval = (req_ff.eval_period == 16'd0) ? twre_pkg::DEFAULT_PERIOD
                                                     : req_ff.eval_period;
      fresh.engage = req_ff.level_a;
      fresh.release_level = req_ff.level_b;
      fresh.last_eval = '0;
      fresh.condition = 1'b0;
      fresh.reference = '0;
      fresh.primed = 1'b0;

      upd = rd_data_ff;
      upd.last_eval = req_ff.time_ms;
      wr_data = upd;

      case (state_ff)
         twre_pkg::S_IDLE: begin
            if (accept) begin
               req_in = req_item;
               scan_in = '0;
               found_in = 1'b0;
               free_found_in = 1'b0;
               if (req_item.action == twre_pkg::ACTION_CLEAR) begin
                  in_use_in = '0;
                  finish = 1'b1;
               end else if (req_item.action == twre_pkg::ACTION_ADD && bad_mode) begin
                  status = twre_pkg::STATUS_BAD_ARGS;
                  finish = 1'b1;
               end
            end
         end
         twre_pkg::S_SCAN: begin
            if (scan_ff != twre_pkg::LAST_SLOT) begin
               scan_in = scan_ff + twre_pkg::SLOT_W'(1);
            end
            if (scan_hit) begin
               found_in = 1'b1;
               slot_in = rd_idx_ff;
            end else if (rd_live_ff && !in_use_ff[rd_idx_ff] && !free_found_ff) begin
               free_found_in = 1'b1;
               free_in = rd_idx_ff;
            end
         end
         twre_pkg::S_APPLY: begin
            case (req_ff.action)
               twre_pkg::ACTION_ADD: begin
                  finish = 1'b1;
                  if (found_ff || free_found_ff) begin
                     wr_en = 1'b1;
                     wr_addr = found_ff ? slot_ff : free_ff;
                     wr_data = fresh;
                     in_use_in[wr_addr] = 1'b1;
                  end else begin
                     status = twre_pkg::STATUS_FULL;
                  end
               end
               twre_pkg::ACTION_REMOVE: begin
                  finish = 1'b1;
                  if (found_ff) begin
                     in_use_in[slot_ff] = 1'b0;
                  end
               end
               twre_pkg::ACTION_SAMPLE: begin
                  finish = !found_ff;
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
         end
         twre_pkg::S_TIME_SUB: begin
            alu_x = zext32(req_ff.time_ms);
            alu_y = zext32(rd_data_ff.last_eval);
         end
         twre_pkg::S_TIME_CMP: begin
            alu_x = zext32(alu_ff[31:0]);
            alu_y = {{(twre_pkg::ALU_W - 16){1'b0}}, rd_data_ff.interval};
         end
         twre_pkg::S_EVAL_A: begin
            if (skip) begin
               finish = 1'b1;
            end else if (!req_ff.sample_valid) begin
               wr_en = 1'b1;
               finish = 1'b1;
            end else begin
               case (rd_data_ff.mode)
                  twre_pkg::MODE_ABOVE: begin
                     alu_x = sext32(req_ff.sample_value);
                     alu_y = sext32(rd_data_ff.condition ? rd_data_ff.release_level
                                                         : rd_data_ff.engage);
                  end
                  twre_pkg::MODE_BELOW: begin
                     alu_x = sext32(rd_data_ff.condition ? rd_data_ff.release_level
                                                         : rd_data_ff.engage);
                     alu_y = sext32(req_ff.sample_value);
                  end
                  twre_pkg::MODE_CHANGED: begin
                     alu_x = sext32(req_ff.sample_value);
                     alu_y = sext32(rd_data_ff.reference);
                  end
                  default: begin
                     alu_x = sext32(req_ff.sample_value);
                     alu_y = sext32(rd_data_ff.engage);
                  end
               endcase
            end
         end
         twre_pkg::S_EVAL_B: begin
            lt1_in = alu_neg;
            if (rd_data_ff.mode == twre_pkg::MODE_CHANGED) begin
               if (alu_neg) begin
                  alu_x = '0;
                  alu_y = alu_ff;
               end else begin
                  alu_x = alu_ff;
                  alu_y = '0;
               end
            end else begin
               alu_x = sext32(rd_data_ff.release_level);
               alu_y = sext32(req_ff.sample_value);
            end
         end
         twre_pkg::S_EVAL_C: begin
            lt2_in = alu_neg;
            alu_x = alu_ff;
            alu_y = sext32(rd_data_ff.engage);
         end
         twre_pkg::S_DECIDE: begin
            if (rd_data_ff.mode == twre_pkg::MODE_CHANGED) begin
               if (!rd_data_ff.primed) begin
                  upd.primed = 1'b1;
                  upd.reference = req_ff.sample_value;
                  ev = |(rd_data_ff.report_mask & twre_pkg::FLAG_INITIAL);
                  ev_state = 1'b1;
               end else if (!alu_neg) begin
                  upd.reference = req_ff.sample_value;
                  run = twre_pkg::RUN_ENTER;
                  ev = 1'b1;
                  ev_state = 1'b1;
               end
            end else begin
               if (!rd_data_ff.primed) begin
                  upd.primed = 1'b1;
                  upd.condition = new_state;
                  run = new_state ? twre_pkg::RUN_ENTER : twre_pkg::RUN_EXIT;
                  ev = |(rd_data_ff.report_mask & twre_pkg::FLAG_INITIAL);
                  ev_state = new_state;
               end else if (new_state != rd_data_ff.condition) begin
                  upd.condition = new_state;
                  run = new_state ? twre_pkg::RUN_ENTER : twre_pkg::RUN_EXIT;
                  ev = new_state ? |(rd_data_ff.report_mask & twre_pkg::FLAG_ENTER)
                                 : |(rd_data_ff.report_mask & twre_pkg::FLAG_EXIT);
                  ev_state = new_state;
               end
            end
            wr_en = 1'b1;
            wr_data = upd;
            finish = 1'b1;
         end
         default: begin
         end
      endcase

      rsp_valid_in = finish;
      rsp_item_in.status = status;
      rsp_item_in.event_valid = ev;
      rsp_item_in.event_rule_id = ev ? req_ff.rule_id : 8'd0;
      rsp_item_in.event_state = ev & ev_state;
      rsp_item_in.event_value = ev ? req_ff.sample_value : 32'sd0;
      rsp_item_in.event_time = ev ? req_ff.time_ms : 32'd0;
      rsp_item_in.action_to_run = run;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= twre_pkg::S_IDLE;
         in_use_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_live_ff <= 1'b0;
         found_ff <= 1'b0;
         free_found_ff <= 1'b0;
         scan_ff <= '0;
      end else begin
         state_ff <= state_in;
         in_use_ff <= in_use_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_live_ff <= rd_live_in;
         found_ff <= found_in;
         free_found_ff <= free_found_in;
         scan_ff <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      slot_ff <= slot_in;
      free_ff <= free_in;
      rd_idx_ff <= rd_addr;
      lt1_ff <= lt1_in;
      lt2_ff <= lt2_in;
      if (rsp_valid_in) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

endmodule

[design/twre_checker.sv]
// Port-level checker for the threshold watch rule engine, bound to its top level.
`include "assert_macros.svh"

module twre_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input twre_pkg::rsp_type rsp_item
);

   logic unused_item;

   assign unused_item = ^rsp_item;

   `ASSERT_NEXT(a_accept_engages, clock, reset, start && !busy, busy || rsp_valid, "accepted transaction neither started work nor gave a result")
   `ASSERT_IMPLY(a_done_gives_result, clock, reset, $fell(busy) && !$past(reset), rsp_valid, "busy fell without a result")
   `ASSERT_IMPLY(a_result_has_cause, clock, reset, rsp_valid, $past(busy) || $past(start), "result shown without a transaction")
   `ASSERT_IMPLY(a_result_when_idle, clock, reset, rsp_valid, !busy, "result shown while still busy")

endmodule

bind threshold_watch_rule_engine_unit twre_checker u_twre_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

[test/testbench.sv]
// Self-checking testbench for the threshold watch rule engine with its own rule table model.
`timescale 1ns / 100ps

module testbench;
   import twre_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;

   threshold_watch_rule_engine_unit u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   req_type            pending_requests[$];
   rsp_type            awaited_outcomes[$];
   int                 queued_count = 0;
   int                 accepted_count = 0;
   int                 error_count = 0;
   logic [31:0]        clock_ms = '0;

   logic               rule_used[RULE_SLOTS];
   logic [7:0]         rule_key[RULE_SLOTS];
   logic [2:0]         rule_mode[RULE_SLOTS];
   logic [2:0]         rule_flags[RULE_SLOTS];
   logic [15:0]        rule_period[RULE_SLOTS];
   logic signed [31:0] rule_level_a[RULE_SLOTS];
   logic signed [31:0] rule_level_b[RULE_SLOTS];
   logic [31:0]        rule_last_seen[RULE_SLOTS];
   logic               rule_active[RULE_SLOTS];
   logic signed [31:0] rule_reference[RULE_SLOTS];
   logic               rule_primed[RULE_SLOTS];

   function automatic rsp_type predict_outcome(input req_type rq);
      rsp_type     rs;
      int          hit;
      logic [31:0] elapsed;
      logic        new_state;
      longint      gap;
      logic        raise;
      logic        raised_state;
      run_type     run;
      rs = '0;
      hit = -1;
      raise = 1'b0;
      raised_state = 1'b0;
      run = RUN_NONE;
      for (int k = 0; k < RULE_SLOTS; k++) begin
         if (hit < 0 && rule_used[k] && rule_key[k] == rq.rule_id) hit = k;
      end
      case (action_type'(rq.action))
         ACTION_ADD: begin
            if (rq.compare_mode > MODE_CHANGED) begin
               rs.status = STATUS_BAD_ARGS;
            end else begin
               for (int k = 0; k < RULE_SLOTS; k++) begin
                  if (hit < 0 && !rule_used[k]) hit = k;
               end
               if (hit < 0) begin
                  rs.status = STATUS_FULL;
               end else begin
                  rule_used[hit] = 1'b1;
                  rule_key[hit] = rq.rule_id;
                  rule_mode[hit] = rq.compare_mode;
                  rule_flags[hit] = rq.event_flags;
                  rule_period[hit] = (rq.eval_period == 16'd0) ? DEFAULT_PERIOD
                                                                : rq.eval_period;
                  rule_level_a[hit] = rq.level_a;
                  rule_level_b[hit] = rq.level_b;
                  rule_last_seen[hit] = '0;
                  rule_active[hit] = 1'b0;
                  rule_primed[hit] = 1'b0;
                  rule_reference[hit] = '0;
               end
            end
         end
         ACTION_REMOVE: begin
            if (hit >= 0) rule_used[hit] = 1'b0;
         end
         ACTION_CLEAR: begin
            for (int k = 0; k < RULE_SLOTS; k++) rule_used[k] = 1'b0;
         end
         default: begin
            if (hit >= 0) begin
               elapsed = rq.time_ms - rule_last_seen[hit];
               if (!(rule_primed[hit] && elapsed < {16'd0, rule_period[hit]})) begin
                  rule_last_seen[hit] = rq.time_ms;
                  if (rq.sample_valid && rule_mode[hit] == MODE_CHANGED) begin
                     if (!rule_primed[hit]) begin
                        rule_primed[hit] = 1'b1;
                        rule_reference[hit] = rq.sample_value;
                        if ((rule_flags[hit] & FLAG_INITIAL) != 3'b000) begin
                           raise = 1'b1;
                           raised_state = 1'b1;
                        end
                     end else begin
                        gap = longint'(rq.sample_value) - longint'(rule_reference[hit]);
                        if (gap < 0) gap = -gap;
                        if (gap >= longint'(rule_level_a[hit])) begin
                           rule_reference[hit] = rq.sample_value;
                           run = RUN_ENTER;
                           raise = 1'b1;
                           raised_state = 1'b1;
                        end
                     end
                  end else if (rq.sample_valid) begin
                     case (rule_mode[hit])
                        MODE_ABOVE: new_state = rule_active[hit] ?
                           !(rq.sample_value < rule_level_b[hit]) :
                           (rq.sample_value >= rule_level_a[hit]);
                        MODE_BELOW: new_state = rule_active[hit] ?
                           !(rq.sample_value > rule_level_b[hit]) :
                           (rq.sample_value <= rule_level_a[hit]);
                        MODE_INSIDE: new_state = (rq.sample_value >= rule_level_a[hit]) &&
                           (rq.sample_value <= rule_level_b[hit]);
                        MODE_OUTSIDE: new_state = (rq.sample_value < rule_level_a[hit]) ||
                           (rq.sample_value > rule_level_b[hit]);
                        default: new_state = 1'b0;
                     endcase
                     if (!rule_primed[hit]) begin
                        rule_primed[hit] = 1'b1;
                        rule_active[hit] = new_state;
                        run = new_state ? RUN_ENTER : RUN_EXIT;
                        if ((rule_flags[hit] & FLAG_INITIAL) != 3'b000) begin
                           raise = 1'b1;
                           raised_state = new_state;
                        end
                     end else if (new_state != rule_active[hit]) begin
                        rule_active[hit] = new_state;
                        run = new_state ? RUN_ENTER : RUN_EXIT;
                        if ((new_state && (rule_flags[hit] & FLAG_ENTER) != 3'b000) ||
                            (!new_state && (rule_flags[hit] & FLAG_EXIT) != 3'b000)) begin
                           raise = 1'b1;
                           raised_state = new_state;
                        end
                     end
                  end
               end
            end
         end
      endcase
      rs.event_valid = raise;
      if (raise) begin
         rs.event_rule_id = rq.rule_id;
         rs.event_state = raised_state;
         rs.event_value = rq.sample_value;
         rs.event_time = rq.time_ms;
      end
      rs.action_to_run = run;
      return rs;
   endfunction

   task automatic queue_request(input logic [1:0] act, input logic [7:0] id,
                                input logic [2:0] mode, input logic [2:0] flags,
                                input logic [15:0] period, input logic signed [31:0] level_a,
                                input logic signed [31:0] level_b,
                                input logic signed [31:0] sample, input logic [31:0] stamp,
                                input logic readable);
      req_type rq;
      rq.action = act;
      rq.rule_id = id;
      rq.compare_mode = mode;
      rq.event_flags = flags;
      rq.eval_period = period;
      rq.level_a = level_a;
      rq.level_b = level_b;
      rq.sample_value = sample;
      rq.time_ms = stamp;
      rq.sample_valid = readable;
      pending_requests.push_back(rq);
      queued_count++;
   endtask

   task automatic queue_sample(input logic [7:0] id, input logic signed [31:0] sample,
                               input logic [31:0] stamp, input logic readable);
      queue_request(ACTION_SAMPLE, id, 3'($urandom), 3'($urandom), 16'($urandom),
                    32'($urandom), 32'($urandom), sample, stamp, readable);
   endtask

   task automatic queue_rule_sequence();
      logic [7:0]         id;
      logic [2:0]         mode;
      logic [15:0]        period;
      logic signed [31:0] centre;
      logic signed [31:0] level_a;
      logic signed [31:0] level_b;
      logic signed [31:0] sample;
      int                 kind;
      int                 width;
      int                 spread;
      int                 span;
      id = 8'($urandom_range(0, 23) * 37);
      mode = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      kind = $urandom_range(0, 9);
      period = (kind == 0) ? 16'd0 : (kind == 1) ? 16'($urandom) : 16'($urandom_range(1, 200));
      span = (period == 16'd0) ? 100 : int'(period);
      kind = $urandom_range(0, 7);
      centre = (kind == 0) ? 32'($urandom) : (kind == 1) ? 32'sh7FFF_FFF0 :
               (kind == 2) ? 32'sh8000_0010 : 32'($urandom_range(0, 1000)) - 32'd500;
      width = $urandom_range(0, 60);
      if (mode == MODE_CHANGED) begin
         kind = $urandom_range(0, 9);
         level_a = (kind == 0) ? 32'($urandom) : (kind == 1) ? -32'sd3 :
                   32'($urandom_range(0, 80));
         spread = (kind >= 2) ? 2 * int'(level_a) + 10 : 1000;
         level_b = 32'($urandom);
      end else begin
         level_a = centre;
         level_b = (mode == MODE_ABOVE) ? centre - width : centre + width;
         if ($urandom_range(0, 7) == 0) level_b = centre - width - 1;
         spread = width + 30;
      end
      if ($urandom_range(0, 14) == 0) clock_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
      queue_request(ACTION_ADD, id, mode, 3'($urandom), period, level_a, level_b,
                    32'($urandom), 32'($urandom), 1'($urandom));
      repeat ($urandom_range(2, 8)) begin
         if (span > 400)
            clock_ms += ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 400);
         else
            clock_ms += $urandom_range(0, 2 * span);
         sample = ($urandom_range(0, 9) == 0) ? 32'($urandom) :
                  centre + 32'($urandom_range(0, 2 * spread)) - 32'(spread);
         queue_sample(id, sample, clock_ms, $urandom_range(0, 9) != 0);
      end
   endtask

   task automatic queue_random_batch(input int target);
      int pick;
      int stop;
      stop = queued_count + target;
      while (queued_count < stop) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            queue_rule_sequence();
         end else if (pick < 75) begin
            clock_ms += $urandom_range(0, 150);
            queue_sample(8'($urandom_range(0, 23) * 37), 32'($urandom), clock_ms,
                         $urandom_range(0, 7) != 0);
         end else if (pick < 85) begin
            queue_request(ACTION_REMOVE, 8'($urandom_range(0, 23) * 37), 3'($urandom),
                          3'($urandom), 16'($urandom), 32'($urandom), 32'($urandom),
                          32'($urandom), 32'($urandom), 1'($urandom));
         end else if (pick < 88) begin
            queue_request(ACTION_CLEAR, 8'($urandom), 3'($urandom), 3'($urandom),
                          16'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
                          32'($urandom), 1'($urandom));
         end else begin
            queue_request(2'($urandom), 8'($urandom), 3'($urandom), 3'($urandom),
                          16'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
                          32'($urandom), 1'($urandom));
         end
      end
   endtask

   task automatic wait_for_drain();
      while (pending_requests.size() != 0 || start || awaited_outcomes.size() != 0)
         @(posedge clock);
   endtask

   task automatic note_mismatch(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: mismatch in %s, expected %h, actual %h", $time, field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      logic rest;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            awaited_outcomes.push_back(predict_outcome(req_item));
            accepted_count++;
         end
         if (!start || !busy) begin
            rest = (accepted_count < 350 || accepted_count >= 520) &&
                   ($urandom_range(0, 99) < 27);
            if (pending_requests.size() != 0 && !rest) begin
               start <= 1'b1;
               req_item <= pending_requests.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (awaited_outcomes.size() == 0) begin
            $display("%0t: result with no transaction outstanding, actual %h", $time, rsp_item);
            error_count++;
         end else begin
            want = awaited_outcomes.pop_front();
            note_mismatch("status", want.status, rsp_item.status);
            note_mismatch("event_valid", want.event_valid, rsp_item.event_valid);
            note_mismatch("event_rule_id", want.event_rule_id, rsp_item.event_rule_id);
            note_mismatch("event_state", want.event_state, rsp_item.event_state);
            note_mismatch("event_value", want.event_value, rsp_item.event_value);
            note_mismatch("event_time", want.event_time, rsp_item.event_time);
            note_mismatch("action_to_run", want.action_to_run, rsp_item.action_to_run);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("threshold_watch_rule_engine_unit verification failed");
      $finish;
   end

   initial begin
      int guard;
      for (int k = 0; k < RULE_SLOTS; k++) rule_used[k] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Hysteresis, the period gate, an unreadable source and the initial report.
      queue_request(ACTION_CLEAR, 8'd0, MODE_ABOVE, 3'd0, 16'd0, 32'sd0, 32'sd0, 32'sd0,
                    32'd0, 1'b0);
      queue_request(ACTION_ADD, 8'd0, MODE_ABOVE, 3'b111, 16'd0, 32'sd10, 32'sd5, 32'sd0,
                    32'd0, 1'b0);
      queue_sample(8'd0, 32'sd10, 32'd1000, 1'b1);
      queue_sample(8'd0, 32'sd0, 32'd1050, 1'b1);
      queue_sample(8'd0, 32'sd7, 32'd1100, 1'b1);
      queue_sample(8'd0, 32'sd4, 32'd1200, 1'b1);
      queue_sample(8'd0, 32'sd20, 32'd1300, 1'b0);
      // Elapsed time across the wrap of the millisecond counter, with the longest period.
      queue_request(ACTION_ADD, 8'd1, MODE_BELOW, 3'b011, 16'hFFFF, -32'sd5, 32'sd0, 32'sd0,
                    32'd0, 1'b1);
      queue_sample(8'd1, 32'sh8000_0000, 32'hFFFF_FFF0, 1'b1);
      queue_sample(8'd1, 32'sh7FFF_FFFF, 32'h0000_0010, 1'b1);
      queue_request(ACTION_ADD, 8'd2, MODE_INSIDE, 3'b100, 16'd1, 32'sh8000_0000,
                    32'sh7FFF_FFFF, 32'sd0, 32'd0, 1'b1);
      queue_sample(8'd2, 32'sd0, 32'd5, 1'b1);
      queue_request(ACTION_ADD, 8'd3, MODE_OUTSIDE, 3'b011, 16'd1, -32'sd1, 32'sd1, 32'sd0,
                    32'd0, 1'b1);
      queue_sample(8'd3, 32'sd0, 32'd5, 1'b1);
      queue_sample(8'd3, 32'sd2, 32'd6, 1'b1);
      // The largest possible change against the largest delta, computed without wrap.
      queue_request(ACTION_ADD, 8'hFF, MODE_CHANGED, 3'b100, 16'd1, 32'sh7FFF_FFFF, 32'sd0,
                    32'sd0, 32'd0, 1'b1);
      queue_sample(8'hFF, 32'sh8000_0000, 32'd9, 1'b1);
      queue_sample(8'hFF, 32'sh7FFF_FFFF, 32'd10, 1'b1);
      queue_request(ACTION_ADD, 8'hFF, 3'd5, 3'b111, 16'd1, 32'sd0, 32'sd0, 32'sd0, 32'd0,
                    1'b1);
      queue_request(ACTION_ADD, 8'h40, 3'd7, 3'b111, 16'd1, 32'sd0, 32'sd0, 32'sd0, 32'd0,
                    1'b1);
      queue_sample(8'd77, 32'sd3, 32'd20, 1'b1);
      queue_request(ACTION_REMOVE, 8'd77, MODE_ABOVE, 3'd0, 16'd0, 32'sd0, 32'sd0, 32'sd0,
                    32'd0, 1'b0);
      queue_request(ACTION_REMOVE, 8'd0, MODE_ABOVE, 3'd0, 16'd0, 32'sd0, 32'sd0, 32'sd0,
                    32'd0, 1'b0);
      queue_sample(8'd0, 32'sd50, 32'd5000, 1'b1);
      queue_request(ACTION_ADD, 8'd2, MODE_CHANGED, 3'b000, 16'd0, -32'sd1, 32'sd0, 32'sd0,
                    32'd0, 1'b1);
      wait_for_drain();

      clock_ms = 32'd5000;
      queue_random_batch(450);
      wait_for_drain();
      queue_random_batch(450);

      while (pending_requests.size() != 0 || start) @(posedge clock);
      guard = 0;
      while (awaited_outcomes.size() != 0 && guard < 2000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
      if (awaited_outcomes.size() != 0) begin
         $display("%0t: %0d transactions never answered", $time, awaited_outcomes.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("threshold_watch_rule_engine_unit verification clean");
      end else begin
         $display("threshold_watch_rule_engine_unit verification failed");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+design
design/twre_pkg.sv
design/twre_alu.sv
design/threshold_watch_rule_engine_unit.sv
design/twre_checker.sv
test/testbench.sv
